// File: rtl/window_coefficient_generator_top_defines.svh
// Assertion macros for the window coefficient generator.
// Included by modules that check their own pipeline; no other dependencies.
`ifndef WINDOW_COEFFICIENT_GENERATOR_TOP_DEFINES_SVH
`define WINDOW_COEFFICIENT_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset
`define WCG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk outside reset
`define WCG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wcg_pkg.sv
// Shared types, constants and tables for the window coefficient generator.
// No dependencies.
package wcg_pkg;

  localparam int MAX_LENGTH    = 4096;
  localparam int FRACTION_BITS = 16;
  localparam int TAP_W         = 12;
  localparam int LEN_W         = 13;
  localparam int COEF_W        = 18;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;

  localparam int DIV_STEPS     = 33;
  localparam int CORDIC_STEPS  = 24;
  localparam int STEP_W        = 5;
  localparam int CW            = 34;   // CORDIC datapath width
  localparam int SUM_W         = 36;

  // stage bookkeeping: meta[k] travels with stage k+1
  localparam int PIPE_DEPTH    = DIV_STEPS + CORDIC_STEPS + 4;
  localparam int META_Q        = DIV_STEPS + CORDIC_STEPS + 1;
  localparam int META_P        = META_Q + 1;
  localparam int META_S        = PIPE_DEPTH - 1;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic [29:0] W054 = 30'd579820585;
  localparam logic [29:0] W046 = 30'd493921239;
  localparam logic [29:0] W042 = 30'd450971566;
  localparam logic [29:0] W008 = 30'd85899346;
  localparam logic [29:0] W050 = 30'd536870912;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  localparam logic [CFG_IDX_W-1:0] REG_TYPE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    WIN_BOXCAR,
    WIN_HANN,
    WIN_HAMMING,
    WIN_BLACKMAN
  } win_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_UNDEF
  } status_t;

  // long-division cell payload
  typedef struct packed {
    logic [LEN_W-1:0]   rem;
    logic [LEN_W-1:0]   dvs;
    logic [DIV_STEPS-1:0] quo;
  } div_t;

  // CORDIC cell payload
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [1:0]           quad;
  } cordic_t;

  typedef struct packed {
    logic    valid;
    win_t    win;
    status_t st;
  } meta_t;

  // arctangent of 2^-k in 2^32-per-turn units
  function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] k);
    logic [29:0] a;
    begin
      case (k)
        5'd0:  a = 30'd536870912;
        5'd1:  a = 30'd316933406;
        5'd2:  a = 30'd167458907;
        5'd3:  a = 30'd85004756;
        5'd4:  a = 30'd42667331;
        5'd5:  a = 30'd21354465;
        5'd6:  a = 30'd10679838;
        5'd7:  a = 30'd5340245;
        5'd8:  a = 30'd2670163;
        5'd9:  a = 30'd1335087;
        5'd10: a = 30'd667544;
        5'd11: a = 30'd333772;
        5'd12: a = 30'd166886;
        5'd13: a = 30'd83443;
        5'd14: a = 30'd41722;
        5'd15: a = 30'd20861;
        5'd16: a = 30'd10430;
        5'd17: a = 30'd5215;
        5'd18: a = 30'd2608;
        5'd19: a = 30'd1304;
        5'd20: a = 30'd652;
        5'd21: a = 30'd326;
        5'd22: a = 30'd163;
        5'd23: a = 30'd81;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

endpackage

// File: rtl/wcg_div_cell.sv
// One restoring long-division cell: one quotient bit per cycle.
// Depends on wcg_pkg.
module wcg_div_cell
  import wcg_pkg::*;
(
  input  logic clk,
  input  div_t din,
  output div_t dout
);

  logic [LEN_W:0] r2;
  logic [LEN_W:0] diff;
  logic           ge;
  div_t           dout_next;

  // shift remainder, trial subtract, emit quotient bit
  always_comb begin
    r2   = {din.rem, 1'b0};
    diff = r2 - {1'b0, din.dvs};
    ge   = (r2 >= {1'b0, din.dvs});
    dout_next.dvs = din.dvs;
    dout_next.rem = ge ? diff[LEN_W-1:0] : r2[LEN_W-1:0];
    dout_next.quo = {din.quo[DIV_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

// File: rtl/wcg_div_chain.sv
// Row of division cells producing a 33-bit fraction floor(r*2^33/d).
// Depends on wcg_pkg and wcg_div_cell.
module wcg_div_chain
  import wcg_pkg::*;
(
  input  logic clk,
  input  div_t din,
  output div_t dout
);

  div_t link [DIV_STEPS+1];

  assign link[0] = din;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_cell
    wcg_div_cell u_cell (
      .clk  (clk),
      .din  (link[s]),
      .dout (link[s+1])
    );
  end

  assign dout = link[DIV_STEPS];

endmodule

// File: rtl/wcg_cordic_cell.sv
// One CORDIC rotation-mode micro-rotation, registered.
// Depends on wcg_pkg.
module wcg_cordic_cell
  import wcg_pkg::*;
(
  input  logic              clk,
  input  logic [STEP_W-1:0] step,
  input  cordic_t           din,
  output cordic_t           dout
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] at;
  cordic_t              dout_next;

  // rotate toward zero residual angle
  always_comb begin
    dx = din.y >>> step;
    dy = din.x >>> step;
    at = $signed({{(CW-30){1'b0}}, atan_turn(step)});
    dout_next.quad = din.quad;
    if (!din.z[CW-1]) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.z = din.z - at;
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

// File: rtl/wcg_cordic_chain.sv
// Row of 24 CORDIC cells turning a 32-bit turn fraction into rotated x/y.
// Depends on wcg_pkg and wcg_cordic_cell.
module wcg_cordic_chain
  import wcg_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] phase,
  output cordic_t     dout
);

  cordic_t link [CORDIC_STEPS+1];

  // start vector: gain-corrected x, angle within the quadrant
  always_comb begin
    link[0].x    = CORDIC_GAIN;
    link[0].y    = '0;
    link[0].z    = $signed({{(CW-30){1'b0}}, phase[29:0]});
    link[0].quad = phase[31:30];
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
    wcg_cordic_cell u_cell (
      .clk  (clk),
      .step (STEP_W'(s)),
      .din  (link[s]),
      .dout (link[s+1])
    );
  end

  assign dout = link[CORDIC_STEPS];

endmodule

// File: rtl/window_coefficient_generator_top.sv
// Window coefficient generator top level: config registers, division and CORDIC rows,
// weighting and output rounding. Depends on wcg_pkg, wcg_div_chain, wcg_cordic_chain.
// Takes one tap index per cycle (busy is high only during reset) and returns its
// coefficient with a one-cycle done strobe; the receiver cannot stall. Each item
// passes the 33-cell division row that forms the phase, the 24-cell CORDIC row,
// and five stages for setup, quadrant fold, weighting multiply, weighted sum and
// output rounding. Results leave in acceptance order. Configuration is snapshotted
// per item at acceptance; the config port is not ready during reset.
`include "window_coefficient_generator_top_defines.svh"

module window_coefficient_generator_top
  import wcg_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [TAP_W-1:0]             tap_index,
  output logic                         done,
  output logic signed [COEF_W-1:0]     coefficient,
  output logic [1:0]                   status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int OUT_SHIFT = 30 - FRACTION_BITS;

  win_t             win_type;
  logic [LEN_W-1:0] win_len;

  logic             accept;
  logic [LEN_W-1:0] n_clamp;
  logic [LEN_W-1:0] idx13;
  logic [LEN_W-1:0] dvs;
  logic [LEN_W-1:0] rem0;
  status_t          st_in;

  div_t    div_in;
  div_t    div_out;
  cordic_t cor1;
  cordic_t cor2;
  meta_t   meta [PIPE_DEPTH];

  logic signed [CW-1:0]  c1;
  logic signed [CW-1:0]  c2;
  logic signed [CW-1:0]  c1_d;
  logic signed [64:0]    p1;
  logic signed [64:0]    p2;
  logic signed [64:0]    p1_r;
  logic signed [64:0]    p2_r;
  logic signed [SUM_W-1:0] wm1;
  logic signed [SUM_W-1:0] wm2;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SUM_W-1:0] rnd;
  logic signed [COEF_W-1:0] coef_next;
  logic [29:0] w1;
  logic [29:0] w2;

  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_type <= WIN_BOXCAR;
      win_len  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TYPE) begin
        win_type <= win_t'(cfg_data[1:0]);
      end else if (cfg_index == REG_LENGTH) begin
        win_len <= cfg_data[LEN_W-1:0];
      end
    end
  end

  // classify the request and set up divisor and first remainder
  always_comb begin
    n_clamp = (win_len > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : win_len;
    idx13   = {1'b0, tap_index};
    if (idx13 >= n_clamp) begin
      st_in = ST_RANGE;
    end else if (n_clamp == LEN_W'(1) &&
                 (win_type == WIN_HAMMING || win_type == WIN_BLACKMAN)) begin
      st_in = ST_UNDEF;
    end else begin
      st_in = ST_OK;
    end
    if (win_type == WIN_HANN) begin
      dvs  = n_clamp + LEN_W'(1);
      rem0 = idx13 + LEN_W'(1);
    end else begin
      dvs  = n_clamp - LEN_W'(1);
      rem0 = (idx13 == dvs) ? '0 : idx13;
    end
  end

  always_ff @(posedge clk) begin
    div_in.rem <= rem0;
    div_in.dvs <= dvs;
    div_in.quo <= '0;
  end

  // side-band pipeline running alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        meta[k] <= '0;
      end
    end else begin
      meta[0] <= '{valid: accept, win: win_type, st: st_in};
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        meta[k] <= meta[k-1];
      end
    end
  end

  wcg_div_chain u_div (
    .clk  (clk),
    .din  (div_in),
    .dout (div_out)
  );

  // phase for the first cosine is the top 32 bits, for the doubled angle the low 32
  wcg_cordic_chain u_cos1 (
    .clk   (clk),
    .phase (div_out.quo[32:1]),
    .dout  (cor1)
  );

  wcg_cordic_chain u_cos2 (
    .clk   (clk),
    .phase (div_out.quo[31:0]),
    .dout  (cor2)
  );

  // quadrant fold
  function automatic logic signed [CW-1:0] fold(input cordic_t c);
    logic signed [CW-1:0] r;
    begin
      unique case (c.quad)
        2'd0: r = c.x;
        2'd1: r = -c.y;
        2'd2: r = -c.x;
        2'd3: r = c.y;
      endcase
      return r;
    end
  endfunction

  always_ff @(posedge clk) begin
    c1 <= fold(cor1);
    c2 <= fold(cor2);
  end

  // weight products
  always_comb begin
    unique case (meta[META_Q].win)
      WIN_HAMMING:  begin w1 = W046; w2 = '0;   end
      WIN_BLACKMAN: begin w1 = W050; w2 = W008; end
      WIN_BOXCAR,
      WIN_HANN:     begin w1 = '0;   w2 = '0;   end
    endcase
    p1 = $signed({1'b0, w1}) * c1;
    p2 = $signed({1'b0, w2}) * c2;
  end

  always_ff @(posedge clk) begin
    p1_r <= p1;
    p2_r <= p2;
    c1_d <= c1;
  end

  // round products to Q30 and form the window sum
  always_comb begin
    wm1 = SUM_W'((p1_r + (65'sd1 <<< 29)) >>> 30);
    wm2 = SUM_W'((p2_r + (65'sd1 <<< 29)) >>> 30);
    unique case (meta[META_P].win)
      WIN_BOXCAR:   sum_next = $signed({{(SUM_W-31){1'b0}}, Q30_ONE});
      WIN_HANN:     sum_next = ($signed({{(SUM_W-31){1'b0}}, Q30_ONE}) -
                                SUM_W'(c1_d)) >>> 1;
      WIN_HAMMING:  sum_next = $signed({{(SUM_W-30){1'b0}}, W054}) - wm1;
      WIN_BLACKMAN: sum_next = $signed({{(SUM_W-30){1'b0}}, W042}) - wm1 + wm2;
    endcase
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

  // round to output precision and saturate
  always_comb begin
    rnd = (sum + (SUM_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (rnd > SUM_W'((1 <<< (COEF_W - 1)) - 1)) begin
      coef_next = {1'b0, {(COEF_W-1){1'b1}}};
    end else if (rnd < -(SUM_W'(1) <<< (COEF_W - 1))) begin
      coef_next = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      coef_next = rnd[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= meta[META_S].valid;
    end
    coefficient <= (meta[META_S].st == ST_OK) ? coef_next : '0;
    status      <= meta[META_S].st;
  end

  `WCG_ASSERT_IMP(a_flag_zero, done && status != ST_OK, coefficient == '0, "flagged result not zero")
  `WCG_ASSERT_NXT(a_cfg_type, cfg_valid && cfg_ready && cfg_index == REG_TYPE, win_type == win_t'($past(cfg_data[1:0])), "window type write lost")
  `WCG_ASSERT_NXT(a_range, accept && {1'b0, tap_index} >= n_clamp, meta[0].st == ST_RANGE && meta[0].valid, "out-of-range index not flagged")
  `WCG_ASSERT_NXT(a_drain, meta[META_S].valid, done, "pipeline item dropped at output")

endmodule

// File: test/window_coefficient_generator_top_tb.sv
// Self-checking testbench for the window coefficient generator top level.
// Depends on wcg_pkg and window_coefficient_generator_top; a scoreboard class predicts taps.
module window_coefficient_generator_top_tb;
  import wcg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // config indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = CFG_IDX_W'(3);
  localparam int LATENCY     = 62;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS       = 1200;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    status_t                  st;
  } tap_result_t;

  // Window predictor plus queue of coefficients still owed by the block
  class window_scoreboard;
    win_t           win_sel;
    int unsigned    win_len;
    tap_result_t    owed[$];
    int             errors;
    int             matched;
    int             taps_by_win[4];

    function new();
      win_sel = WIN_BOXCAR;
      win_len = 0;
      errors  = 0;
      matched = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_TYPE) win_sel = win_t'(data[1:0]);
      else if (idx == REG_LENGTH) win_len = data;
    endfunction

    // 24-step rotation-mode CORDIC on a 32-bit turn fraction, Q30 result
    function longint cos_turn(longint unsigned ph);
      longint x, y, z, dx, dy;
      logic [1:0] quad;
      quad = ph[31:30];
      z = longint'(ph[29:0]);
      x = 652032874;
      y = 0;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_turn(STEP_W'(k)));
        end else begin
          x += dx; y -= dy; z += longint'(atan_turn(STEP_W'(k)));
        end
      end
      case (quad)
        2'd0: return x;
        2'd1: return -y;
        2'd2: return -x;
        default: return y;
      endcase
    endfunction

    function longint unsigned turn_of(longint unsigned k, longint unsigned d);
      return ((k << 32) / d) & 64'hFFFF_FFFF;
    endfunction

    function longint weigh(longint w, longint c);
      return (w * c + (longint'(1) << 29)) >>> 30;
    endfunction

    function logic signed [COEF_W-1:0] round_q30(longint q);
      longint v;
      v = (q + (longint'(1) << (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return COEF_W'(v);
    endfunction

    function void note_tap(logic [TAP_W-1:0] tap);
      tap_result_t r;
      longint unsigned i, n;
      longint c1, c2;
      i = tap;
      n = (win_len > MAX_LENGTH) ? MAX_LENGTH : win_len;
      r.coef = '0;
      r.st   = ST_OK;
      taps_by_win[win_sel]++;
      if (i >= n) r.st = ST_RANGE;
      else if (n == 1 && win_sel >= WIN_HAMMING) r.st = ST_UNDEF;
      else begin
        case (win_sel)
          WIN_BOXCAR: r.coef = round_q30(longint'(1) << 30);
          WIN_HANN: begin
            c1 = cos_turn(turn_of(i + 1, n + 1));
            r.coef = round_q30((longint'(Q30_ONE) - c1) >>> 1);
          end
          WIN_HAMMING: begin
            c1 = cos_turn(turn_of(i, n - 1));
            r.coef = round_q30(longint'(W054) - weigh(longint'(W046), c1));
          end
          default: begin
            c1 = cos_turn(turn_of(i, n - 1));
            c2 = cos_turn(turn_of(2 * i, n - 1));
            r.coef = round_q30(longint'(W042) - weigh(longint'(W050), c1)
                               + weigh(longint'(W008), c2));
          end
        endcase
      end
      owed.push_back(r);
    endfunction

    function void check(logic signed [COEF_W-1:0] coef, logic [1:0] st);
      tap_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result coefficient %0d status %0d", $time, coef, st);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (coef !== e.coef) begin
        $display("%0t: coefficient expected %0d actual %0d", $time, e.coef, coef);
        errors++;
      end
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
      if (coef === e.coef && st === e.st) matched++;
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [TAP_W-1:0]         tap_index = '0;
  logic                     done;
  logic signed [COEF_W-1:0] coefficient;
  logic [1:0]               status;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  window_scoreboard sb = new();
  int unsigned cycles = 0;
  int          sent = 0;
  int          gap_pct = 18;

  window_coefficient_generator_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .tap_index(tap_index),
    .done(done), .coefficient(coefficient), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Input and result monitors; values read here are the pre-edge ones
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_tap(tap_index);
    if (!rst && done) sb.check(coefficient, status);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one tap and hold it until the transfer; then idle each cycle with
  // probability gap_pct, so that share of cycles is idle; start is left low after a gap
  task automatic send_tap(logic [TAP_W-1:0] tap);
    start     <= 1'b1;
    tap_index <= tap;
    do @(posedge clk); while (busy);
    sent++;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and let every owed coefficient come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic set_window(win_t w, logic [CFG_DATA_W-1:0] len);
    drain();
    write_cfg(REG_TYPE, CFG_DATA_W'(w));
    write_cfg(REG_LENGTH, len);
  endtask

  // Taps mostly inside the window, some anywhere
  function automatic logic [TAP_W-1:0] pick_tap();
    int unsigned n;
    n = (sb.win_len > MAX_LENGTH) ? MAX_LENGTH : sb.win_len;
    if (n > 0 && $urandom_range(99) < 85) return TAP_W'($urandom_range(n - 1));
    return TAP_W'($urandom);
  endfunction

  initial begin
    int unsigned len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: degenerate lengths, one-tap windows, oversized length, tap extremes
    set_window(WIN_BOXCAR, 0);
    send_tap(0); send_tap(TAP_W'(4095));
    set_window(WIN_HANN, 1);
    send_tap(0); send_tap(1);
    set_window(WIN_HAMMING, 1);
    send_tap(0); send_tap(TAP_W'(4095));
    set_window(WIN_BLACKMAN, 1);
    send_tap(0);
    set_window(WIN_HAMMING, 2);
    send_tap(0); send_tap(1); send_tap(2);
    set_window(WIN_BLACKMAN, 13'd4096);
    send_tap(0); send_tap(TAP_W'(2048)); send_tap(TAP_W'(4095));
    set_window(WIN_HANN, 13'h1FFF);
    send_tap(0); send_tap(TAP_W'(4095));
    set_window(WIN_BOXCAR, 13'd4097);
    send_tap(TAP_W'(4095));
    // spare indexes must leave the registers alone
    drain();
    write_cfg(REG_SPARE2, 13'h1555);
    write_cfg(REG_SPARE3, 13'h0AAA);
    send_tap(TAP_W'(4095)); send_tap(TAP_W'(2730));
    set_window(WIN_BLACKMAN, 3);
    send_tap(0); send_tap(1); send_tap(2);

    // Random phases, each a fresh window
    while (sent < ITEMS + 25) begin
      if (sent > (ITEMS + 25) * 2 / 3) gap_pct = 0;
      else if (sent > (ITEMS + 25) / 3) gap_pct = 82;
      case ($urandom_range(9))
        0:       len = $urandom_range(8191);
        1:       len = $urandom_range(4094, 4098);
        2:       len = $urandom_range(3);
        default: len = $urandom_range(2, 300);
      endcase
      if ($urandom_range(3) == 0) begin
        drain();
        write_cfg(REG_LENGTH, CFG_DATA_W'(len));
      end else begin
        set_window(win_t'($urandom_range(3)), CFG_DATA_W'(len));
      end
      repeat ($urandom_range(10, 60)) send_tap(pick_tap());
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    $display("Sent %0d taps (boxcar %0d, hann %0d, hamming %0d, blackman %0d), %0d matched.",
             sent, sb.taps_by_win[0], sb.taps_by_win[1], sb.taps_by_win[2],
             sb.taps_by_win[3], sb.matched);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
